FILE: src/dpfm_pkg.sv
// ----------------------------------------------------------------------------
// dpfm_pkg
// Shared types, constants and a text page helper for the demand paging byte memory.
// ----------------------------------------------------------------------------
package dpfm_pkg;

    localparam int PG_BYTES   = 8;
    localparam int PAGE_BITS  = 3;
    localparam int NUM_PAGES  = 32;
    localparam int PAGE_W     = 5;
    localparam int NUM_FRAMES = 8;
    localparam int FRAME_W    = 3;
    localparam int VADDR_W    = PAGE_W + PAGE_BITS;
    localparam int ADDR_W     = 9;
    localparam int CFG_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = FRAME_W + 1;

    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'd48;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_IMAGE = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_UNALLOC = 2'd2;
    localparam logic [1:0] ST_TEXT    = 2'd3;

    localparam logic REG_TEXT_SIZE = 1'b0;
    localparam logic REG_DATA_SIZE = 1'b1;

    typedef enum logic [1:0] {
        SRC_IMG  = 2'd0,
        SRC_SWAP = 2'd1,
        SRC_FILL = 2'd2
    } t_src;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_LOOK = 13'b0000000000010,
        S_HIT  = 13'b0000000000100,
        S_FILL = 13'b0000000001000,
        S_MAP  = 13'b0000000010000,
        S_ACC  = 13'b0000000100000,
        S_RD   = 13'b0000001000000,
        S_EVQ  = 13'b0000010000000,
        S_EVF  = 13'b0000100000000,
        S_EVX  = 13'b0001000000000,
        S_EVC  = 13'b0010000000000,
        S_EVD  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic [PAGE_BITS-1:0] rd_off;
        logic                 wr_en;
        logic [PAGE_BITS-1:0] wr_off;
        logic                 done;
    } t_copy_ctl;

    function automatic logic f_is_text(input logic [PAGE_W-1:0] page,
                                       input logic [CFG_W-1:0] text);
        return {1'b0, page} < text[CFG_W-1:PAGE_BITS];
    endfunction

endpackage

FILE: src/demand_paging_fifo_mmu.sv
// ----------------------------------------------------------------------------
// demand_paging_fifo_mmu
// Demand paged byte memory with FIFO page replacement and swap.
// ----------------------------------------------------------------------------
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+-----------------------------------
// request  | i_valid     | o_ready     | i_command, i_address, i_value
// result   | o_valid     | i_ready     | o_read_data, o_status
// config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time. A miss adds a page copy into a free frame, and an
// eviction adds a copy of the evicted page to swap (none for a text page),
// both run by the shared byte copy sequencer.
// Reset is synchronous; no clearing pass. A held result stalls only the
// next result, not the next request's transfer.
// ----------------------------------------------------------------------------
module demand_paging_fifo_mmu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_command,
    input  logic [dpfm_pkg::ADDR_W-1:0]    i_address,
    input  logic [dpfm_pkg::BYTE_W-1:0]    i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dpfm_pkg::BYTE_W-1:0]    o_read_data,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [dpfm_pkg::CFG_W-1:0]     i_cfg_data
);
    import dpfm_pkg::*;

    t_state                  r_state, n_state;
    logic [1:0]              r_cmd, n_cmd;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic [BYTE_W-1:0]       r_val, n_val;
    logic [CFG_W-1:0]        r_text, r_dsize;
    logic [NUM_PAGES-1:0]    r_valid, n_valid;
    logic [NUM_PAGES-1:0]    r_dirty, n_dirty;
    logic [NUM_PAGES-1:0]    r_swpw, n_swpw;
    logic [NUM_FRAMES-1:0]   r_used, n_used;
    logic [FRAME_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [FRAME_W-1:0]      r_frame, n_frame;
    t_src                    r_src, n_src;
    logic                    r_miss, n_miss;
    logic [BYTE_W-1:0]       r_rd_res, n_rd_res;
    logic [1:0]              r_st_res, n_st_res;
    logic [PAGE_W-1:0]       r_evpage, n_evpage;
    logic [FRAME_W-1:0]      r_evframe, n_evframe;
    logic                    r_ev_nt, n_ev_nt;
    logic                    r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]       r_out_data;
    logic [1:0]              r_out_status;

    logic [FRAME_W-1:0]      r_pf_mem [NUM_PAGES];
    logic [FRAME_W-1:0]      r_pf_q;
    logic [PAGE_W-1:0]       r_fifo_mem [NUM_FRAMES];
    logic [PAGE_W-1:0]       r_fifo_q;
    logic [BYTE_W-1:0]       r_frm_mem [NUM_FRAMES*PG_BYTES];
    logic [BYTE_W-1:0]       r_frm_q;
    logic [BYTE_W-1:0]       r_swp_mem [NUM_PAGES*PG_BYTES];
    logic [BYTE_W-1:0]       r_swp_q;
    logic [BYTE_W-1:0]       r_img_mem [NUM_PAGES*PG_BYTES];
    logic [BYTE_W-1:0]       r_img_q;

    logic [PAGE_W-1:0]       w_page;
    logic [PAGE_BITS-1:0]    w_off;
    logic                    w_text;
    logic                    w_in_data;
    logic [FRAME_W-1:0]      w_free;
    logic                    w_cp_start;
    t_copy_ctl               w_cp;
    logic                    w_done_fire;
    logic [FRAME_W-1:0]      w_push_idx;
    logic                    w_frm_we;
    logic [FRAME_W+PAGE_BITS-1:0] w_frm_addr;
    logic [BYTE_W-1:0]       w_frm_wd;
    logic                    w_img_we;
    logic [VADDR_W-1:0]      w_img_addr;
    logic                    w_swp_we;
    logic [VADDR_W-1:0]      w_swp_addr;
    logic [PAGE_W-1:0]       w_pf_addr;

    dpfm_copy u_copy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cp_start),
        .o_ctl   (w_cp)
    );

    assign w_page    = r_addr[VADDR_W-1:PAGE_BITS];
    assign w_off     = r_addr[PAGE_BITS-1:0];
    assign w_text    = f_is_text(w_page, r_text);
    assign w_in_data = {1'b0, r_addr} < ({1'b0, r_text} + {1'b0, r_dsize});
    assign w_push_idx = r_head + r_count[FRAME_W-1:0];

    always_comb begin
        w_free = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = FRAME_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_val      = r_val;
        n_valid    = r_valid;
        n_dirty    = r_dirty;
        n_swpw     = r_swpw;
        n_used     = r_used;
        n_head     = r_head;
        n_count    = r_count;
        n_frame    = r_frame;
        n_src      = r_src;
        n_miss     = r_miss;
        n_rd_res   = r_rd_res;
        n_st_res   = r_st_res;
        n_evpage   = r_evpage;
        n_evframe  = r_evframe;
        n_ev_nt    = r_ev_nt;
        w_cp_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_addr   = i_address;
                    n_val    = i_value;
                    n_rd_res = '0;
                    n_st_res = ST_OK;
                    n_miss   = 1'b0;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                priority if (r_cmd == CMD_NONE) begin
                    n_st_res = ST_OK;
                end else if (r_addr[ADDR_W-1:VADDR_W] != '0) begin
                    n_st_res = ST_BAD;
                end else if (r_cmd == CMD_IMAGE) begin
                    n_st_res = ST_OK;
                end else if (r_cmd == CMD_STORE && w_text) begin
                    n_st_res = ST_TEXT;
                end else if (r_valid[w_page]) begin
                    n_state = S_HIT;
                end else if (r_cmd == CMD_LOAD && !w_text && !r_dirty[w_page]
                             && !w_in_data) begin
                    n_st_res = ST_UNALLOC;
                end else begin
                    if (w_text) begin
                        n_src = SRC_IMG;
                    end else if (r_dirty[w_page]) begin
                        n_src = r_swpw[w_page] ? SRC_SWAP : SRC_FILL;
                    end else begin
                        n_src = w_in_data ? SRC_IMG : SRC_FILL;
                    end
                    n_frame    = w_free;
                    n_miss     = 1'b1;
                    w_cp_start = 1'b1;
                    n_state    = S_FILL;
                end
            end
            S_HIT: begin
                n_frame = r_pf_q;
                n_state = S_ACC;
            end
            S_FILL: begin
                if (w_cp.done) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_valid[w_page] = 1'b1;
                n_used[r_frame] = 1'b1;
                if (r_count < CNT_W'(NUM_FRAMES)) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_cmd == CMD_LOAD) begin
                    n_state = S_RD;
                end else begin
                    n_dirty[w_page] = 1'b1;
                    n_state = (r_miss && (&r_used)) ? S_EVQ : S_DONE;
                end
            end
            S_RD: begin
                n_rd_res = r_frm_q;
                n_state  = (r_miss && (&r_used)) ? S_EVQ : S_DONE;
            end
            S_EVQ: begin
                n_state = (r_count == '0) ? S_DONE : S_EVF;
            end
            S_EVF: begin
                n_evpage = r_fifo_q;
                n_state  = S_EVX;
            end
            S_EVX: begin
                n_evframe = r_pf_q;
                n_ev_nt   = !f_is_text(r_evpage, r_text);
                if (!f_is_text(r_evpage, r_text)) begin
                    w_cp_start = 1'b1;
                    n_state    = S_EVC;
                end else begin
                    n_state = S_EVD;
                end
            end
            S_EVC: begin
                if (w_cp.done) begin
                    n_state = S_EVD;
                end
            end
            S_EVD: begin
                if (r_ev_nt) begin
                    n_dirty[r_evpage] = 1'b1;
                    n_swpw[r_evpage]  = 1'b1;
                end
                n_valid[r_evpage] = 1'b0;
                n_used[r_evframe] = 1'b0;
                n_head  = r_head + 1'b1;
                n_count = r_count - 1'b1;
                if (r_cmd == CMD_LOAD && r_evpage == w_page) begin
                    n_rd_res = FILL_BYTE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_done_fire = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign n_out_valid = w_done_fire || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_swpw      <= '0;
            r_used      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_miss      <= 1'b0;
            r_ev_nt     <= 1'b0;
            r_out_valid <= 1'b0;
            r_text      <= '0;
            r_dsize     <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_swpw      <= n_swpw;
            r_used      <= n_used;
            r_head      <= n_head;
            r_count     <= n_count;
            r_miss      <= n_miss;
            r_ev_nt     <= n_ev_nt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TEXT_SIZE: r_text  <= i_cfg_data;
                    REG_DATA_SIZE: r_dsize <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_val     <= n_val;
        r_frame   <= n_frame;
        r_src     <= n_src;
        r_rd_res  <= n_rd_res;
        r_st_res  <= n_st_res;
        r_evpage  <= n_evpage;
        r_evframe <= n_evframe;
        if (w_done_fire) begin
            r_out_data   <= r_rd_res;
            r_out_status <= r_st_res;
        end
    end

    // frame memory
    assign w_frm_we = ((r_state == S_FILL) && w_cp.wr_en)
                   || ((r_state == S_ACC) && (r_cmd == CMD_STORE));

    always_comb begin
        if (r_state == S_FILL) begin
            w_frm_addr = {r_frame, w_cp.wr_off};
        end else if (r_state == S_EVC) begin
            w_frm_addr = {r_evframe, w_cp.rd_off};
        end else begin
            w_frm_addr = {r_frame, w_off};
        end
        if (r_state == S_FILL) begin
            unique case (r_src)
                SRC_IMG:  w_frm_wd = r_img_q;
                SRC_SWAP: w_frm_wd = r_swp_q;
                default:  w_frm_wd = FILL_BYTE;
            endcase
        end else begin
            w_frm_wd = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frm_we) begin
            r_frm_mem[w_frm_addr] <= w_frm_wd;
        end
        r_frm_q <= r_frm_mem[w_frm_addr];
    end

    // program image
    assign w_img_we   = (r_state == S_LOOK) && (r_cmd == CMD_IMAGE)
                     && (r_addr[ADDR_W-1:VADDR_W] == '0);
    assign w_img_addr = (r_state == S_LOOK) ? r_addr[VADDR_W-1:0] : {w_page, w_cp.rd_off};

    always_ff @(posedge i_clk) begin
        if (w_img_we) begin
            r_img_mem[w_img_addr] <= r_val;
        end
        r_img_q <= r_img_mem[w_img_addr];
    end

    // swap, valid per page once written by an eviction
    assign w_swp_we   = (r_state == S_EVC) && w_cp.wr_en;
    assign w_swp_addr = (r_state == S_EVC) ? {r_evpage, w_cp.wr_off}
                                           : {w_page, w_cp.rd_off};

    always_ff @(posedge i_clk) begin
        if (w_swp_we) begin
            r_swp_mem[w_swp_addr] <= r_frm_q;
        end
        r_swp_q <= r_swp_mem[w_swp_addr];
    end

    // page to frame map
    assign w_pf_addr = (r_state == S_EVF) ? r_fifo_q : w_page;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP) begin
            r_pf_mem[w_pf_addr] <= r_frame;
        end
        r_pf_q <= r_pf_mem[w_pf_addr];
    end

    // replacement queue
    always_ff @(posedge i_clk) begin
        if ((r_state == S_MAP) && (r_count < CNT_W'(NUM_FRAMES))) begin
            r_fifo_mem[w_push_idx] <= w_page;
        end
        r_fifo_q <= r_fifo_mem[r_head];
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_used) == int'(r_count)))
        else $error("queue depth differs from resident frame count");

    a_free_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(&r_used))
        else $error("no free frame left between requests");

    a_copy_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cp.done |-> ((r_state == S_FILL) || (r_state == S_EVC)))
        else $error("page copy finished outside a copy state");

    a_valid_resident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_valid) == $countones(r_used)))
        else $error("mapped page count differs from resident frame count");
`endif

endmodule

FILE: src/dpfm_copy.sv
// ----------------------------------------------------------------------------
// dpfm_copy
// Page copy sequencer: issues one byte read per cycle, each write in the cycle after its read.
// ----------------------------------------------------------------------------
module dpfm_copy (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output dpfm_pkg::t_copy_ctl  o_ctl
);
    import dpfm_pkg::*;

    localparam logic [PAGE_BITS-1:0] LAST = PAGE_BITS'(PG_BYTES - 1);

    logic                 r_run, n_run;
    logic [PAGE_BITS-1:0] r_cnt, n_cnt;
    logic                 r_wv;
    logic [PAGE_BITS-1:0] r_woff;

    always_comb begin
        n_run = r_run;
        n_cnt = r_cnt;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
        end else if (r_run) begin
            if (r_cnt == LAST) begin
                n_run = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
            r_wv  <= 1'b0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
            r_wv  <= r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_woff <= r_cnt;
    end

    assign o_ctl.rd_off = r_cnt;
    assign o_ctl.wr_en  = r_wv;
    assign o_ctl.wr_off = r_woff;
    assign o_ctl.done   = r_wv && (r_woff == LAST);

endmodule
